// ===== hw/rtl/rle_pkg.sv =====
package rle_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RNG_W = 9;
  localparam int unsigned IDX_W = (CNT_W > RNG_W) ? CNT_W : RNG_W;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ENT_W = 31;
  localparam int unsigned LCM_W = 63;
  localparam int unsigned ST_W = 3;
  localparam int unsigned DIV_CNT_W = $clog2(LCM_W);
  localparam int unsigned MUL_CNT_W = $clog2(ENT_W);
  localparam int unsigned SHF_W = $clog2(ENT_W);

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_RANGE = 3'd1,
    ST_NONPOS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CMD_APPEND = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_XL,
    S_MOD_GO,
    S_MOD_W,
    S_GCD_GO,
    S_GCD_W,
    S_DIV_GO,
    S_DIV_W,
    S_MUL_GO,
    S_MUL_W,
    S_RESP
  } state_e;

endpackage

// ===== hw/rtl/rle_if.sv =====
interface rle_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [rle_pkg::VAL_W-1:0]  value;
  logic [rle_pkg::RNG_W-1:0]  range_start;
  logic [rle_pkg::RNG_W-1:0]  range_end;

  modport source (output valid, command, value, range_start, range_end, input ready);
  modport sink (input valid, command, value, range_start, range_end, output ready);
endinterface

interface rle_out_if;
  logic                       valid;
  logic                       ready;
  logic [rle_pkg::LCM_W-1:0]  lcm_value;
  logic [rle_pkg::ST_W-1:0]   status;

  modport source (output valid, lcm_value, status, input ready);
  modport sink (input valid, lcm_value, status, output ready);
endinterface

// ===== hw/rtl/range_lcm_engine_unit.sv =====
// Range LCM engine. An append transfer stores a positive value in the next table
// slot and goes straight to its response; a query transfer answers the LCM of
// entries [range_start, range_end), or zero with an error status on a bad range
// or overflow. Queries run one entry at a time: a table read, then bit-serial
// units for a remainder, a binary GCD, a quotient and a multiply. One item is
// worked on at a time; the result register lets the next input transfer be
// taken while a result waits.
module range_lcm_engine_unit (
  input logic   clk_i,
  input logic   rst_ni,
  rle_in_if.sink    in_i,
  rle_out_if.source out_o
);
  import rle_pkg::*;

  state_e           state_q, state_d;
  logic [ENT_W-1:0] table_mem [TABLE_DEPTH];
  logic [ENT_W-1:0] rd_q, x_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] idx_q, end_q, in_start, in_end, in_cnt;
  logic [LCM_W-1:0] run_q, lcm_q;
  status_e          st_q, out_st_q;
  logic             query_q;
  logic             out_valid_q;
  logic             acc_in, out_free, out_load;
  logic             mod_go, gcd_go, div_go, mul_go;
  logic             div_done, gcd_done, mul_done, mul_ovf;
  logic [LCM_W-1:0] div_dvd, div_quo, mul_prod;
  logic [ENT_W-1:0] div_dvs, div_rem, gcd_val;
  logic             is_append, nonpos, full, bad;
  logic             last;

  assign acc_in   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_start = IDX_W'(in_i.range_start);
  assign in_end   = IDX_W'(in_i.range_end);
  assign in_cnt   = IDX_W'(count_q);
  assign is_append = (in_i.command == CMD_APPEND);
  assign nonpos   = in_i.value[VAL_W-1] || (in_i.value == '0);
  assign full     = (count_q == CNT_W'(TABLE_DEPTH));
  assign bad      = (in_start >= in_end) || (in_end > in_cnt);
  assign last     = (idx_q + 1'b1) == end_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          state_d = (is_append || bad) ? S_RESP : S_RD;
        end
      end
      S_RD:     state_d = S_XL;
      S_XL:     state_d = S_MOD_GO;
      S_MOD_GO: state_d = S_MOD_W;
      S_MOD_W:  if (div_done) state_d = S_GCD_GO;
      S_GCD_GO: state_d = S_GCD_W;
      S_GCD_W:  if (gcd_done) state_d = S_DIV_GO;
      S_DIV_GO: state_d = S_DIV_W;
      S_DIV_W:  if (div_done) state_d = S_MUL_GO;
      S_MUL_GO: state_d = S_MUL_W;
      S_MUL_W: begin
        if (mul_done) begin
          state_d = (mul_ovf || last) ? S_RESP : S_RD;
        end
      end
      S_RESP:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == S_IDLE);
    mod_go     = (state_q == S_MOD_GO);
    gcd_go     = (state_q == S_GCD_GO);
    div_go     = (state_q == S_DIV_GO);
    mul_go     = (state_q == S_MUL_GO);
    out_load   = (state_q == S_RESP) && out_free;
    div_dvd    = run_q;
    div_dvs    = (state_q == S_MOD_GO) ? x_q : gcd_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc_in && is_append && !nonpos && !full) begin
        count_q <= count_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && is_append && !nonpos && !full) begin
      table_mem[count_q[ADDR_W-1:0]] <= in_i.value[ENT_W-1:0];
    end
    rd_q <= table_mem[idx_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      idx_q   <= in_start;
      end_q   <= in_end;
      run_q   <= LCM_W'(1);
      query_q <= !is_append;
      priority if (is_append && nonpos) st_q <= ST_NONPOS;
      else if (is_append && full)       st_q <= ST_FULL;
      else if (!is_append && bad)       st_q <= ST_BAD_RANGE;
      else                              st_q <= ST_OK;
    end
    if (state_q == S_XL) begin
      x_q <= rd_q;
    end
    if (state_q == S_MUL_W && mul_done) begin
      if (mul_ovf) begin
        st_q <= ST_OVERFLOW;
      end else begin
        run_q <= mul_prod;
        idx_q <= idx_q + 1'b1;
      end
    end
    if (out_load) begin
      lcm_q    <= (st_q == ST_OK && query_q) ? run_q : '0;
      out_st_q <= st_q;
    end
  end

  rle_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_go || div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  rle_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_go),
    .a_i     (x_q),
    .b_i     (div_rem),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  rle_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_go),
    .mcand_i  (div_quo),
    .mplier_i (x_q),
    .done_o   (mul_done),
    .ovf_o    (mul_ovf),
    .prod_o   (mul_prod)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.lcm_value = lcm_q;
  assign out_o.status    = out_st_q;
endmodule

// ===== hw/rtl/rle_div.sv =====
module rle_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rle_pkg::LCM_W-1:0] dividend_i,
  input  logic [rle_pkg::ENT_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [rle_pkg::LCM_W-1:0] quo_o,
  output logic [rle_pkg::ENT_W-1:0] rem_o
);
  import rle_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [LCM_W-1:0]     quo_q;
  logic [ENT_W-1:0]     rem_q, dvs_q;
  logic [ENT_W:0]       trial, diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[LCM_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(LCM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[ENT_W-1:0] : trial[ENT_W-1:0];
      quo_q <= {quo_q[LCM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== hw/rtl/rle_gcd.sv =====
module rle_gcd (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rle_pkg::ENT_W-1:0] a_i,
  input  logic [rle_pkg::ENT_W-1:0] b_i,
  output logic                      done_o,
  output logic [rle_pkg::ENT_W-1:0] gcd_o
);
  import rle_pkg::*;

  logic             busy_q, done_q;
  logic [ENT_W-1:0] a_q, b_q, g_q;
  logic [SHF_W-1:0] k_q;
  logic             fin;

  // binary gcd, one shift or subtract per cycle
  assign fin = (a_q == '0) || (b_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && fin) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      k_q <= '0;
    end else if (busy_q) begin
      priority if (b_q == '0) begin
        g_q <= a_q << k_q;
      end else if (a_q == '0) begin
        g_q <= b_q << k_q;
      end else if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;
endmodule

// ===== hw/rtl/rle_mul.sv =====
module rle_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rle_pkg::LCM_W-1:0] mcand_i,
  input  logic [rle_pkg::ENT_W-1:0] mplier_i,
  output logic                      done_o,
  output logic                      ovf_o,
  output logic [rle_pkg::LCM_W-1:0] prod_o
);
  import rle_pkg::*;

  logic                 busy_q, done_q, ovf_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [LCM_W-1:0]     mc_q, acc_q;
  logic [ENT_W-1:0]     mp_q;
  logic [LCM_W:0]       sum;

  // multiplier bits MSB first; partial product only grows, so overflow is sticky
  assign sum = {1'b0, acc_q[LCM_W-2:0], 1'b0} + (mp_q[ENT_W-1] ? {1'b0, mc_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == MUL_CNT_W'(ENT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q  <= mcand_i;
      mp_q  <= mplier_i;
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      ovf_q <= ovf_q | acc_q[LCM_W-1] | sum[LCM_W];
      acc_q <= sum[LCM_W-1:0];
      mp_q  <= mp_q << 1;
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign prod_o = acc_q;
endmodule

// ===== hw/rtl/rle_checker.sv =====
module rle_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rle_pkg::LCM_W-1:0] lcm_value_i,
  input logic [rle_pkg::ST_W-1:0]  status_i
);
  import rle_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result dropped while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second transfer taken while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_W'(ST_OVERFLOW))
    else $error("unknown status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_W'(ST_OK) |-> lcm_value_i == '0)
    else $error("nonzero value with error status");
endmodule

bind range_lcm_engine_unit rle_checker u_rle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .lcm_value_i (out_o.lcm_value),
  .status_i    (out_o.status)
);
